FILE: hw/rtl/q2rm_pkg.sv
`timescale 1ns / 1ps
// Package for the quaternion to rotation matrix unit.
// Fixed-point widths, product slot indexes and the Q2.14 unit constant; no dependencies.
package q2rm_pkg;

  localparam int unsigned CompW   = 16;  // Q1.15 component
  localparam int unsigned ElemW   = 16;  // Q2.14 matrix element
  localparam int unsigned NumElem = 9;
  localparam int unsigned NumProd = 10;
  localparam int unsigned ProdW   = 32;  // exact Q2.30 product
  localparam int unsigned NormW   = 33;  // squared norm, up to 2^32
  localparam int unsigned NumerW  = 35;  // signed element numerator
  localparam int unsigned MagW    = 34;
  localparam int unsigned DivW    = 34;  // divisor 2n
  localparam int unsigned RemW    = 49;  // (mag << 15) + n
  localparam int unsigned QuotW   = 15;  // quotient never exceeds 2^14

  localparam logic [ElemW-1:0] Q14_ONE = 16'sd16384;

  // product slots
  localparam int unsigned P_XX = 0;
  localparam int unsigned P_YY = 1;
  localparam int unsigned P_ZZ = 2;
  localparam int unsigned P_WW = 3;
  localparam int unsigned P_XY = 4;
  localparam int unsigned P_XZ = 5;
  localparam int unsigned P_YZ = 6;
  localparam int unsigned P_WX = 7;
  localparam int unsigned P_WY = 8;
  localparam int unsigned P_WZ = 9;

  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [NumerW-1:0] numer_t;
  typedef logic        [RemW-1:0]   rem_t;
  typedef logic        [QuotW-1:0]  quot_t;

endpackage

FILE: hw/rtl/quaternion_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// Quaternion to 3x3 rotation matrix, Q1.15 in, Q2.14 out, fully pipelined.
// Depends on q2rm_pkg.
// Pipeline: 19 register stages: products, sums, divider setup, 15 restoring
// divider bit stages, output register.
// Throughput: one quaternion per cycle while the output is not back-pressured; the nine dividers are unrolled one
// quotient bit per stage, each stage with its own valid bit and ready chain.
// Reset: rst_ni clears all valid bits asynchronously; data registers are not reset.
module quaternion_to_rotation_matrix_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         m_axis_tuser    // zero_norm
);
  import q2rm_pkg::*;

  localparam int unsigned NDiv = QuotW;

  // stage 1: products
  logic  v1_q;
  prod_t prod_q [NumProd];
  // stage 2: norm and numerators
  logic             v2_q;
  logic [NormW-1:0] norm_q;
  numer_t           numer_q [NumElem];
  // divider stages 0..NDiv
  logic              vd_q    [NDiv+1];
  rem_t              rem_q   [NDiv+1][NumElem];
  quot_t             quot_q  [NDiv+1][NumElem];
  logic [NumElem-1:0] neg_q  [NDiv+1];
  logic [DivW-1:0]   dvs_q   [NDiv+1];
  logic              zero_q  [NDiv+1];
  // output
  logic             out_v_q;
  logic [143:0]     out_data_q;
  logic             out_zero_q;

  logic en_out, en1, en2;
  logic en_d [NDiv+1];

  always_comb begin
    en_out = !out_v_q || m_axis_tready;
    en_d[NDiv] = !vd_q[NDiv] || en_out;
    for (int j = NDiv - 1; j >= 0; j--) begin
      en_d[j] = !vd_q[j] || en_d[j+1];
    end
    en2 = !v2_q || en_d[0];
    en1 = !v1_q || en2;
  end

  assign s_axis_tready = en1;

  // stage 1 inputs
  logic signed [CompW-1:0] qx, qy, qz, qw;
  assign qx = s_axis_tdata[15:0];
  assign qy = s_axis_tdata[31:16];
  assign qz = s_axis_tdata[47:32];
  assign qw = s_axis_tdata[63:48];

  // stage 2 sums
  logic [NormW-1:0] norm_d;
  numer_t           numer_d [NumElem];
  numer_t           pe [NumProd];

  always_comb begin
    for (int i = 0; i < NumProd; i++) begin
      pe[i] = NumerW'(prod_q[i]);
    end
    norm_d = NormW'(pe[P_XX] + pe[P_YY] + pe[P_ZZ] + pe[P_WW]);
    numer_d[0] = pe[P_WW] + pe[P_XX] - pe[P_YY] - pe[P_ZZ];
    numer_d[1] = (pe[P_XY] + pe[P_WZ]) <<< 1;
    numer_d[2] = (pe[P_XZ] - pe[P_WY]) <<< 1;
    numer_d[3] = (pe[P_XY] - pe[P_WZ]) <<< 1;
    numer_d[4] = pe[P_WW] - pe[P_XX] + pe[P_YY] - pe[P_ZZ];
    numer_d[5] = (pe[P_YZ] + pe[P_WX]) <<< 1;
    numer_d[6] = (pe[P_XZ] + pe[P_WY]) <<< 1;
    numer_d[7] = (pe[P_YZ] - pe[P_WX]) <<< 1;
    numer_d[8] = pe[P_WW] - pe[P_XX] - pe[P_YY] + pe[P_ZZ];
  end

  // divider setup: remainder = (|N| << 15) + n, divisor = 2n
  rem_t               rem0_d  [NumElem];
  logic [NumElem-1:0] neg0_d;
  logic [MagW-1:0]    mag;

  always_comb begin
    mag = '0;
    for (int i = 0; i < NumElem; i++) begin
      neg0_d[i] = numer_q[i][NumerW-1];
      mag = neg0_d[i] ? MagW'(-numer_q[i]) : MagW'(numer_q[i]);
      rem0_d[i] = (RemW'(mag) << 15) + RemW'(norm_q);
    end
  end

  // one restoring quotient bit per stage
  rem_t  rem_d  [1:NDiv][NumElem];
  quot_t quot_d [1:NDiv][NumElem];
  rem_t  shifted;

  always_comb begin
    shifted = '0;
    for (int j = 1; j <= NDiv; j++) begin
      shifted = RemW'(dvs_q[j-1]) << (NDiv - j);
      for (int i = 0; i < NumElem; i++) begin
        quot_d[j][i] = quot_q[j-1][i];
        if (rem_q[j-1][i] >= shifted) begin
          rem_d[j][i] = rem_q[j-1][i] - shifted;
          quot_d[j][i][NDiv-j] = 1'b1;
        end else begin
          rem_d[j][i] = rem_q[j-1][i];
        end
      end
    end
  end

  // sign and identity select
  logic [143:0] out_data_d;
  logic [ElemW-1:0] mag_e;

  always_comb begin
    mag_e = '0;
    for (int i = 0; i < NumElem; i++) begin
      mag_e = ElemW'(quot_q[NDiv][i]);
      if (zero_q[NDiv]) begin
        out_data_d[i*ElemW +: ElemW] = (i % 4 == 0) ? Q14_ONE : '0;
      end else begin
        out_data_d[i*ElemW +: ElemW] = neg_q[NDiv][i] ? -mag_e : mag_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j <= NDiv; j++) begin
        vd_q[j] <= 1'b0;
      end
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en_d[0]) vd_q[0] <= v2_q;
      for (int j = 1; j <= NDiv; j++) begin
        if (en_d[j]) vd_q[j] <= vd_q[j-1];
      end
      if (en_out) out_v_q <= vd_q[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q[P_XX] <= qx * qx;
      prod_q[P_YY] <= qy * qy;
      prod_q[P_ZZ] <= qz * qz;
      prod_q[P_WW] <= qw * qw;
      prod_q[P_XY] <= qx * qy;
      prod_q[P_XZ] <= qx * qz;
      prod_q[P_YZ] <= qy * qz;
      prod_q[P_WX] <= qw * qx;
      prod_q[P_WY] <= qw * qy;
      prod_q[P_WZ] <= qw * qz;
    end
    if (en2) begin
      norm_q  <= norm_d;
      numer_q <= numer_d;
    end
    if (en_d[0]) begin
      rem_q[0]  <= rem0_d;
      neg_q[0]  <= neg0_d;
      dvs_q[0]  <= DivW'(norm_q) << 1;
      zero_q[0] <= (norm_q == '0);
      for (int i = 0; i < NumElem; i++) begin
        quot_q[0][i] <= '0;
      end
    end
    for (int j = 1; j <= NDiv; j++) begin
      if (en_d[j]) begin
        rem_q[j]  <= rem_d[j];
        quot_q[j] <= quot_d[j];
        neg_q[j]  <= neg_q[j-1];
        dvs_q[j]  <= dvs_q[j-1];
        zero_q[j] <= zero_q[j-1];
      end
    end
    if (en_out) begin
      out_data_q <= out_data_d;
      out_zero_q <= zero_q[NDiv];
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_zero_q;

`ifndef NO_ASSERTIONS
  // identity on zero norm
  a_zero_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[15:0] == Q14_ONE && m_axis_tdata[31:16] == '0 &&
       m_axis_tdata[143:128] == Q14_ONE))
    else $error("zero norm result is not identity");

  // input backpressure only comes from a full pipe behind a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // m00 and m12 stay within [-1.0, 1.0]
  a_range_m00: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
       $signed(m_axis_tdata[15:0]) >= -16'sd16384))
    else $error("m00 out of range");

  a_range_m12: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[95:80]) <= 16'sd16384 &&
       $signed(m_axis_tdata[95:80]) >= -16'sd16384))
    else $error("m12 out of range");
`endif

endmodule
